// File: rtl/core/fmr_pkg.sv
// Shared types and constants for the framed message receiver.
// No dependencies; used by every module under rtl/core except fmr_ram.
package fmr_pkg;

	localparam int QUEUE_SLOTS_DEF = 4;
	localparam int MAX_PAYLOAD_DEF = 128;
	localparam int CMDQ_DEPTH      = 4;

	// framing bytes
	localparam logic [7:0] SOH_BYTE  = 8'h01;
	localparam logic [7:0] STX_BYTE  = 8'h02;
	localparam logic [7:0] ETX_BYTE  = 8'h03;
	localparam logic [7:0] EOT_BYTE  = 8'h04;
	localparam logic [7:0] ACK_NO    = 8'h00;
	localparam logic [7:0] ACK_YES   = 8'hFF;

	// configuration register indexes
	localparam int         CFG_IDX_W   = 1;
	localparam logic [0:0] CFG_CHK_EN  = 1'd0;
	localparam logic [0:0] CFG_MAX_LEN = 1'd1;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_STORED   = 3'd1,
		EV_CSUM_NAK = 3'd2,
		EV_EOT_NAK  = 3'd3,
		EV_DROPPED  = 3'd4
	} ev_t;

	// where the back end takes the header of a result from
	typedef enum logic [1:0] {
		SEL_ZERO  = 2'd0,
		SEL_FRAME = 2'd1,
		SEL_HEAD  = 2'd2
	} sel_t;

	typedef struct packed {
		logic        ack;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [7:0]  sys;
		logic [7:0]  mtype;
		logic [15:0] serial;
		logic [7:0]  size;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic       chk_en;
		logic [7:0] max_bytes;
	} cfg_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic       ready;
		ev_t        ev;
		sel_t       sel;
		logic       rd;
		logic [6:0] ri;
		hdr_t       hdr;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

endpackage

// File: rtl/core/fmr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/fmr_front.sv
// Front end: deframes received bytes, keeps the slot ring counters and
// classifies each word into a command for the back end. Uses fmr_pkg.
module fmr_front #(
	parameter int QUEUE_SLOTS = fmr_pkg::QUEUE_SLOTS_DEF,
	parameter int MAX_PAYLOAD = fmr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  fmr_pkg::cfg_t                               cfg,
	input  logic                                        accept,
	input  logic [1:0]                                  opcode,
	input  logic [7:0]                                  rx_byte,
	input  logic [6:0]                                  read_index,
	output fmr_pkg::cmd_t                               cmd,
	output logic [$clog2(QUEUE_SLOTS)-1:0]              cmd_slot,
	output logic                                        pay_pend,
	output logic                                        pay_we,
	output logic [$clog2(QUEUE_SLOTS*MAX_PAYLOAD)-1:0]  pay_waddr,
	output logic                                        hdr_we,
	output logic [$clog2(QUEUE_SLOTS)-1:0]              hdr_waddr,
	output fmr_pkg::hdr_t                               hdr_wdata
);
	import fmr_pkg::*;

	localparam int SLOT_W = $clog2(QUEUE_SLOTS);
	localparam int USED_W = $clog2(QUEUE_SLOTS + 1);
	localparam int PAY_AW = $clog2(QUEUE_SLOTS * MAX_PAYLOAD);

	typedef enum logic [3:0] {
		PH_SOH, PH_ACK, PH_SRC, PH_DST, PH_SYS, PH_TYPE, PH_SERH, PH_SERL,
		PH_SIZEH, PH_SIZEL, PH_STX, PH_PAY, PH_ETX, PH_CS, PH_EOT
	} ph_t;

	ph_t               ph_q, ph_d;
	logic [7:0]        cnt_q, cnt_d;
	logic [7:0]        cs_q, cs_d;
	hdr_t              hdr_q, hdr_d;
	logic              shi_q, shi_d;
	logic              drop_q, drop_d;
	logic [SLOT_W-1:0] head_q, head_d;
	logic [SLOT_W-1:0] tail_q, tail_d;
	logic [USED_W-1:0] used_q, used_d;
	logic [7:0]        limit;
	logic              full;
	ev_t               ev;

	assign limit = (cfg.max_bytes > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : cfg.max_bytes;
	assign full  = (used_q >= USED_W'(QUEUE_SLOTS));

	// a received byte taken now would land in the payload store
	assign pay_pend = (ph_q == PH_PAY) && !drop_q && (cnt_q < 8'(MAX_PAYLOAD));

	always_comb begin
		ph_d   = ph_q;
		cnt_d  = cnt_q;
		cs_d   = cs_q;
		hdr_d  = hdr_q;
		shi_d  = shi_q;
		drop_d = drop_q;
		head_d = head_q;
		tail_d = tail_q;
		used_d = used_q;
		ev     = EV_NONE;
		pay_we = 1'b0;
		hdr_we = 1'b0;
		if (accept) begin
			case (opcode)
				OP_BYTE: begin
					unique case (ph_q)
						PH_ACK: begin
							if (rx_byte != ACK_NO && rx_byte != ACK_YES) begin
								ph_d = PH_SOH;
							end else begin
								hdr_d.ack = (rx_byte == ACK_YES);
								cs_d      = cs_q ^ rx_byte;
								ph_d      = PH_SRC;
							end
						end
						PH_SRC: begin
							hdr_d.src = rx_byte;
							cs_d      = cs_q ^ rx_byte;
							ph_d      = PH_DST;
						end
						PH_DST: begin
							hdr_d.dst = rx_byte;
							cs_d      = cs_q ^ rx_byte;
							ph_d      = PH_SYS;
						end
						PH_SYS: begin
							hdr_d.sys = rx_byte;
							cs_d      = cs_q ^ rx_byte;
							ph_d      = PH_TYPE;
						end
						PH_TYPE: begin
							hdr_d.mtype = rx_byte;
							cs_d        = cs_q ^ rx_byte;
							ph_d        = PH_SERH;
						end
						PH_SERH: begin
							hdr_d.serial = {rx_byte, 8'h00};
							cs_d         = cs_q ^ rx_byte;
							ph_d         = PH_SERL;
						end
						PH_SERL: begin
							hdr_d.serial = {hdr_q.serial[15:8], rx_byte};
							cs_d         = cs_q ^ rx_byte;
							ph_d         = PH_SIZEH;
						end
						PH_SIZEH: begin
							shi_d = (rx_byte != 8'h00);
							ph_d  = PH_SIZEL;
						end
						PH_SIZEL: begin
							if (shi_q || rx_byte > limit) begin
								ph_d = PH_SOH;
							end else begin
								hdr_d.size = rx_byte;
								ph_d       = PH_STX;
							end
						end
						PH_STX: begin
							if (rx_byte == STX_BYTE) begin
								// sample fullness once per frame
								drop_d = full;
								cnt_d  = 8'h00;
								ph_d   = (hdr_q.size == 8'h00) ? PH_ETX : PH_PAY;
							end else begin
								ph_d = PH_SOH;
							end
						end
						PH_PAY: begin
							pay_we = !drop_q && (cnt_q < 8'(MAX_PAYLOAD));
							cs_d   = cs_q ^ rx_byte;
							cnt_d  = cnt_q + 8'd1;
							if (cnt_d >= hdr_q.size) begin
								ph_d = PH_ETX;
							end
						end
						PH_ETX: begin
							ph_d = (rx_byte == ETX_BYTE) ? PH_CS : PH_SOH;
						end
						PH_CS: begin
							if (cfg.chk_en && cs_q != rx_byte) begin
								ev   = EV_CSUM_NAK;
								ph_d = PH_SOH;
							end else begin
								ph_d = PH_EOT;
							end
						end
						PH_EOT: begin
							if (rx_byte == EOT_BYTE) begin
								if (drop_q || full) begin
									ev = EV_DROPPED;
								end else begin
									hdr_we = 1'b1;
									tail_d = (tail_q == SLOT_W'(QUEUE_SLOTS - 1)) ?
										'0 : tail_q + SLOT_W'(1);
									used_d = used_q + USED_W'(1);
									ev     = EV_STORED;
								end
							end else begin
								ev = EV_EOT_NAK;
							end
							ph_d = PH_SOH;
						end
						default: begin
							// hunt for SOH; start a fresh frame on it
							if (rx_byte == SOH_BYTE) begin
								cs_d  = 8'h00;
								cnt_d = 8'h00;
								hdr_d = '0;
								shi_d = 1'b0;
								ph_d  = PH_ACK;
							end else begin
								ph_d = PH_SOH;
							end
						end
					endcase
				end
				OP_RELEASE: begin
					if (used_q != '0) begin
						head_d = (head_q == SLOT_W'(QUEUE_SLOTS - 1)) ?
							'0 : head_q + SLOT_W'(1);
						used_d = used_q - USED_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cmd.ready = (used_d != '0);
		cmd.ev    = ev;
		if (ev != EV_NONE) begin
			cmd.sel = SEL_FRAME;
		end else if (used_d != '0) begin
			cmd.sel = SEL_HEAD;
		end else begin
			cmd.sel = SEL_ZERO;
		end
		cmd.rd   = (opcode == OP_READ) && (used_q != '0);
		cmd.ri   = read_index;
		// frame header is unchanged on every step that reports an event
		cmd.hdr  = hdr_q;
		cmd_slot = head_d;
	end

	assign pay_waddr = PAY_AW'(tail_q) * PAY_AW'(MAX_PAYLOAD) + PAY_AW'(cnt_q);
	assign hdr_waddr = tail_q;
	assign hdr_wdata = hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_SOH;
			cnt_q  <= '0;
			cs_q   <= '0;
			hdr_q  <= '0;
			shi_q  <= 1'b0;
			drop_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
		end else begin
			ph_q   <= ph_d;
			cnt_q  <= cnt_d;
			cs_q   <= cs_d;
			hdr_q  <= hdr_d;
			shi_q  <= shi_d;
			drop_q <= drop_d;
			head_q <= head_d;
			tail_q <= tail_d;
			used_q <= used_d;
		end
	end

endmodule

// File: rtl/core/fmr_cmd_fifo.sv
// Short command queue between the front and back ends.
// Uses fmr_pkg for its default depth.
module fmr_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = fmr_pkg::CMDQ_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/core/fmr_back.sv
// Back end: fetches header and payload from the slot stores for each command
// and drives the registered result channel. Uses fmr_pkg.
module fmr_back #(
	parameter int QUEUE_SLOTS = fmr_pkg::QUEUE_SLOTS_DEF,
	parameter int MAX_PAYLOAD = fmr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        q_valid,
	input  fmr_pkg::cmd_t                               q_cmd,
	input  logic [$clog2(QUEUE_SLOTS)-1:0]              q_slot,
	output logic                                        q_pop,
	output logic [$clog2(QUEUE_SLOTS)-1:0]              hdr_raddr,
	input  fmr_pkg::hdr_t                               hdr_rdata,
	output logic [$clog2(QUEUE_SLOTS*MAX_PAYLOAD)-1:0]  pay_raddr,
	input  logic [7:0]                                  pay_rdata,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [71:0]                                 m_tdata,
	output logic [2:0]                                  m_tuser
);
	import fmr_pkg::*;

	localparam int PAY_AW = $clog2(QUEUE_SLOTS * MAX_PAYLOAD);

	logic              v_s1;
	cmd_t              cmd_s1;
	logic              out_load;
	logic              ri_ok;
	logic [PAY_AW-1:0] base;
	hdr_t              hdr;
	logic [7:0]        pbyte;

	// RAM read data holds while stage 1 waits, since reads go with the pop
	assign out_load  = v_s1 && (!m_tvalid || m_tready);
	assign q_pop     = q_valid && (!v_s1 || out_load);
	assign ri_ok     = ({1'b0, q_cmd.ri} < 8'(MAX_PAYLOAD));
	assign base      = PAY_AW'(q_slot) * PAY_AW'(MAX_PAYLOAD);
	assign pay_raddr = ri_ok ? base + PAY_AW'(q_cmd.ri) : base;
	assign hdr_raddr = q_slot;

	always_comb begin
		case (cmd_s1.sel)
			SEL_FRAME: hdr = cmd_s1.hdr;
			SEL_HEAD:  hdr = hdr_rdata;
			default:   hdr = '0;
		endcase
		if (cmd_s1.rd && ({1'b0, cmd_s1.ri} < hdr_rdata.size) &&
				({1'b0, cmd_s1.ri} < 8'(MAX_PAYLOAD))) begin
			pbyte = pay_rdata;
		end else begin
			pbyte = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_cmd;
		end
		if (out_load) begin
			m_tdata <= {6'b0, pbyte, hdr.ack, hdr.size, hdr.serial, hdr.mtype,
				hdr.sys, hdr.dst, hdr.src, cmd_s1.ready};
			m_tuser <= cmd_s1.ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (q_pop) begin
				v_s1 <= 1'b1;
			end else if (out_load) begin
				v_s1 <= 1'b0;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/framed_message_receiver.sv
// Framed message receiver: byte deframer with a ring of message slots.
// Depends on fmr_pkg, fmr_ram, fmr_front, fmr_cmd_fifo and fmr_back.
// Usage
//   Input words (s_*): s_tuser carries the opcode - received byte, read head
//   message or release head message. s_tdata carries the received byte and,
//   for a read, the payload index. Every accepted word yields exactly one
//   result word on m_*: the event code on m_tuser, the queue status, the
//   header (of the frame just ended when there is an event, else of the head
//   message, else zero) and, for a read, one payload byte on m_tdata.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle:
//   index 0 enables checksum checking, index 1 sets the largest payload.
// Timing
//   One word a cycle sustained while s_tready stays high. A result passes
//   through the command queue, the registered read of the header and
//   payload stores and the output register before it appears on m_tdata.
// Stalls and reset
//   s_tready drops while the four-deep command queue is full, and holds off a
//   payload byte while a head read still waits in the queue (a freed slot may
//   be refilled). Reset returns the parser to hunting for SOH, empties ring
//   and queue and restores the configuration defaults; stores are not cleared.
module framed_message_receiver #(
	parameter int QUEUE_SLOTS = fmr_pkg::QUEUE_SLOTS_DEF,
	parameter int MAX_PAYLOAD = fmr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,  // rx_byte[7:0], read_index[14:8]
	input  logic [1:0]                    s_tuser,  // opcode[1:0]
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// message_ready[0], source_address[8:1], dest_address[16:9],
	// system_id[24:17], message_type[32:25], serial_number[48:33],
	// payload_size[56:49], ack_requested[57], payload_byte[65:58]
	output logic [71:0]                   m_tdata,
	output logic [2:0]                    m_tuser,  // event_res[2:0]
	// configuration
	input  logic                          cfg_we,
	input  logic [fmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import fmr_pkg::*;

	localparam int SLOT_W    = $clog2(QUEUE_SLOTS);
	localparam int PAY_DEPTH = QUEUE_SLOTS * MAX_PAYLOAD;
	localparam int PAY_AW    = $clog2(PAY_DEPTH);
	localparam int QW        = SLOT_W + CMD_W;
	localparam int RD_W      = $clog2(CMDQ_DEPTH + 1);

	cfg_t              cfg_q;
	logic              accept;
	cmd_t              f_cmd;
	logic [SLOT_W-1:0] f_slot;
	logic              pay_pend;
	logic              pay_hold;
	logic [RD_W-1:0]   rd_pend_q;
	logic              pay_we;
	logic [PAY_AW-1:0] pay_waddr;
	logic              hdr_we;
	logic [SLOT_W-1:0] hdr_waddr;
	hdr_t              hdr_wdata;
	logic [QW-1:0]     q_rdata;
	logic              q_empty, q_full, q_pop;
	cmd_t              b_cmd;
	logic [SLOT_W-1:0] b_slot;
	logic [SLOT_W-1:0] hdr_raddr;
	hdr_t              hdr_rdata;
	logic [PAY_AW-1:0] pay_raddr;
	logic [7:0]        pay_rdata;

	// Configuration registers: the user must write them only while the block is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chk_en    <= 1'b0;
			cfg_q.max_bytes <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHK_EN:  cfg_q.chk_en    <= cfg_data[0];
				CFG_MAX_LEN: cfg_q.max_bytes <= cfg_data;
				default:     cfg_q           <= cfg_q;
			endcase
		end
	end

	// Count head reads still waiting in the command queue; their payload is
	// fetched only when they leave it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= '0;
		end else begin
			case ({accept && f_cmd.rd, q_pop && b_cmd.rd})
				2'b10:   rd_pend_q <= rd_pend_q + RD_W'(1);
				2'b01:   rd_pend_q <= rd_pend_q - RD_W'(1);
				default: rd_pend_q <= rd_pend_q;
			endcase
		end
	end

	// Hold a payload byte until waiting reads have fetched their data, so a
	// released slot is not overwritten underneath them
	assign pay_hold = pay_pend && (s_tuser == OP_BYTE) && (rd_pend_q != '0);

	// Hold off the sender when the command queue is full or a payload write must wait
	assign s_tready = !q_full && !pay_hold;
	assign accept   = s_tvalid && s_tready;

	fmr_front #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.opcode     (s_tuser),
		.rx_byte    (s_tdata[7:0]),
		.read_index (s_tdata[14:8]),
		.cmd        (f_cmd),
		.cmd_slot   (f_slot),
		.pay_pend   (pay_pend),
		.pay_we     (pay_we),
		.pay_waddr  (pay_waddr),
		.hdr_we     (hdr_we),
		.hdr_waddr  (hdr_waddr),
		.hdr_wdata  (hdr_wdata)
	);

	// Decouple the parser from the result channel
	fmr_cmd_fifo #(
		.WIDTH (QW),
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  ({f_slot, f_cmd}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign b_slot = q_rdata[QW-1 -: SLOT_W];
	assign b_cmd  = cmd_t'(q_rdata[CMD_W-1:0]);

	// Header of every stored message, one row per slot
	fmr_ram #(
		.WIDTH (HDR_W),
		.DEPTH (QUEUE_SLOTS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (hdr_waddr),
		.wdata (hdr_wdata),
		.re    (q_pop),
		.raddr (hdr_raddr),
		.rdata (hdr_rdata)
	);

	// Payload bytes, MAX_PAYLOAD per slot
	fmr_ram #(
		.WIDTH (8),
		.DEPTH (PAY_DEPTH)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (s_tdata[7:0]),
		.re    (q_pop),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	fmr_back #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_empty),
		.q_cmd     (b_cmd),
		.q_slot    (b_slot),
		.q_pop     (q_pop),
		.hdr_raddr (hdr_raddr),
		.hdr_rdata (hdr_rdata),
		.pay_raddr (pay_raddr),
		.pay_rdata (pay_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// A stored frame always leaves at least one message queued
	a_stored_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_STORED |-> m_tdata[0])
		else $error("stored frame reported with empty queue");

	// With no event and an empty queue the header reads as zero
	a_empty_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_NONE && !m_tdata[0] |-> m_tdata[57:1] == '0)
		else $error("non-zero header with empty queue");

	// A payload byte only comes with a plain read, never with a frame event
	a_pbyte_no_ev: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_NONE |-> m_tdata[65:58] == 8'h00)
		else $error("payload byte alongside a frame event");

	// The queue never takes a word it has no room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !q_pop |=> q_full)
		else $error("command queue lost an entry");

endmodule
